// ===== rtl/pida_pkg.sv =====
// ----------------------------------------------------------------------------
// pida_pkg : shared types and constants for the positional insert/delete array
// Holds the capacity, the field widths and the codes used by the block.
// ----------------------------------------------------------------------------
package pida_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_DELETE  = 2'd1,
    KIND_DISPLAY = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_DEL_END,
    S_DISP_RD,
    S_DISP_OUT,
    S_REPLY
  } state_t;

endpackage

// ===== rtl/pida_ram.sv =====
// ----------------------------------------------------------------------------
// pida_ram : element store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pida_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wen,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              ren,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/positional_insert_delete_array.sv =====
// ----------------------------------------------------------------------------
// positional_insert_delete_array : ordered list with insert/delete at position
// Sequencer over a one-read, one-write element RAM and one shared +/-1 index
// adder.
// ----------------------------------------------------------------------------
// Usage:
//   Drive kind/position/value and raise start; the command transfers on a
//   rising edge with start high and busy low. busy stays high until the last
//   result of that command has been shown.
//   Results appear for exactly one cycle each, marked by strobe; last flags
//   the final result of the command. The receiver cannot stall, so every
//   result must be taken in the cycle it is shown.
//   Steps after the transfer, up to and including the last result:
//     insert at p : one RAM read and one write per element moved up, then
//                   the new value is put and the status is shown.
//     delete at p : one read and one write per element moved down, then
//                   the count drops and the status is shown.
//     display     : per element, a registered RAM read, then the emit.
//     rejected commands, empty display, unused kind: the status alone.
//   busy drops in the cycle after the last result, so the next command
//   cannot transfer before then.
//   The rate is set by the single RAM port pair and the shared index adder,
//   which step one element per move.
//   Reset clears the count and the sequencer; the element RAM is not cleared,
//   since only entries below count are ever read.
// ----------------------------------------------------------------------------
module positional_insert_delete_array (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind,
  input  logic [6:0]                  position,
  input  logic signed [31:0]          value,
  output logic                        strobe,
  output logic [1:0]                  status,
  output logic signed [31:0]          element,
  output logic [5:0]                  element_index,
  output logic [6:0]                  element_count,
  output logic                        last
);

  import pida_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] ptr;
  logic [CNT_W-1:0]  pos;
  logic [DATA_W-1:0] val;
  status_t           st;

  // Shared index unit: ptr +/- 1 and the compares that follow it
  logic              dec;
  logic [CNT_W-1:0]  step;
  logic              ptr_at_pos;
  logic              step_at_count;

  // RAM port signals
  logic              wen;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic              ren;
  logic [ADDR_W-1:0] raddr;
  logic [DATA_W-1:0] rdata;

  logic              accept;

  assign accept        = start && (state == S_IDLE);
  assign dec           = (state == S_INS_RD) || (state == S_INS_WR);
  assign step          = dec ? (CNT_W'(ptr) - CNT_W'(1)) : (CNT_W'(ptr) + CNT_W'(1));
  assign ptr_at_pos    = (CNT_W'(ptr) == pos);
  assign step_at_count = (step == count);

  pida_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .wen   (wen),
    .waddr (waddr),
    .wdata (wdata),
    .ren   (ren),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (kind_t'(kind))
            KIND_INSERT: begin
              if (position > count || count == CNT_W'(CAPACITY)) begin
                state_next = S_REPLY;
              end else begin
                state_next = S_INS_RD;
              end
            end
            KIND_DELETE: begin
              if (position >= count) begin
                state_next = S_REPLY;
              end else begin
                state_next = S_DEL_RD;
              end
            end
            KIND_DISPLAY: begin
              if (count == '0) begin
                state_next = S_REPLY;
              end else begin
                state_next = S_DISP_RD;
              end
            end
            default: state_next = S_REPLY;
          endcase
        end
      end
      S_INS_RD:   state_next = ptr_at_pos ? S_INS_PUT : S_INS_WR;
      S_INS_WR:   state_next = S_INS_RD;
      S_INS_PUT:  state_next = S_REPLY;
      S_DEL_RD:   state_next = step_at_count ? S_DEL_END : S_DEL_WR;
      S_DEL_WR:   state_next = S_DEL_RD;
      S_DEL_END:  state_next = S_REPLY;
      S_DISP_RD:  state_next = S_DISP_OUT;
      S_DISP_OUT: state_next = step_at_count ? S_IDLE : S_DISP_RD;
      S_REPLY:    state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs and RAM control
  always_comb begin
    wen           = 1'b0;
    waddr         = ptr;
    wdata         = rdata;
    ren           = 1'b0;
    raddr         = step[ADDR_W-1:0];
    busy          = (state != S_IDLE);
    strobe        = 1'b0;
    status        = ST_OK;
    element       = '0;
    element_index = '0;
    element_count = count;
    last          = 1'b0;
    case (state)
      S_INS_RD: begin
        // fetch the element below the hole unless the hole reached pos
        ren = !ptr_at_pos;
      end
      S_INS_WR: begin
        wen = 1'b1;
      end
      S_INS_PUT: begin
        wen   = 1'b1;
        waddr = pos[ADDR_W-1:0];
        wdata = val;
      end
      S_DEL_RD: begin
        ren = !step_at_count;
      end
      S_DEL_WR: begin
        wen = 1'b1;
      end
      S_DISP_RD: begin
        ren   = 1'b1;
        raddr = ptr;
      end
      S_DISP_OUT: begin
        strobe        = 1'b1;
        status        = ST_OK;
        element       = rdata;
        element_index = 6'(ptr);
        last          = step_at_count;
      end
      S_REPLY: begin
        strobe = 1'b1;
        status = st;
        last   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_INS_PUT: count <= count + CNT_W'(1);
        S_DEL_END: count <= count - CNT_W'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos <= position;
      val <= value;
      st  <= ST_OK;
      case (kind_t'(kind))
        KIND_INSERT: begin
          // check position before fullness
          if (position > count) begin
            st <= ST_BADPOS;
          end else if (count == CNT_W'(CAPACITY)) begin
            st <= ST_FULL;
          end
          ptr <= count[ADDR_W-1:0];
        end
        KIND_DELETE: begin
          if (position >= count) begin
            st <= ST_BADPOS;
          end
          ptr <= position[ADDR_W-1:0];
        end
        KIND_DISPLAY: begin
          if (count == '0) begin
            st <= ST_EMPTY;
          end
          ptr <= '0;
        end
        default: begin
          ptr <= '0;
        end
      endcase
    end else begin
      case (state)
        // advance the pointer after each move or emitted element
        S_INS_WR, S_DEL_WR: ptr <= step[ADDR_W-1:0];
        S_DISP_OUT: begin
          if (!step_at_count) begin
            ptr <= step[ADDR_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : testbench for positional_insert_delete_array
// Sends insert, delete, display and unused-kind commands over the start/busy
// handshake. A behavioral copy of the list in this file predicts every result
// of each accepted command, and a checker compares each strobed result with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import pida_pkg::*;

  // Generous cycle limit: the slowest commands are an insert at 0 and a display
  // of a full list, and the run sends about 400 commands.
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    status_t            status;
    logic signed [31:0] element;
    logic [5:0]         index;
    logic [6:0]         count;
    logic               last;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         kind;
  logic [6:0]         position;
  logic signed [31:0] value;
  logic               strobe;
  logic [1:0]         status;
  logic signed [31:0] element;
  logic [5:0]         element_index;
  logic [6:0]         element_count;
  logic               last;

  // Behavioral image of the list held by the block.
  logic signed [31:0] list_image [CAPACITY];
  int unsigned        list_len;

  // Predicted results, oldest first.
  list_result_t       awaited_results [$];

  int                 mismatches  = 0;
  int                 cycle_count = 0;
  int                 results_seen = 0;
  bit                 idle_enable = 1'b1;

  positional_insert_delete_array dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .position      (position),
    .value         (value),
    .strobe        (strobe),
    .status        (status),
    .element       (element),
    .element_index (element_index),
    .element_count (element_count),
    .last          (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Queue one predicted result; count is the list length after the command.
  function automatic void push_result(status_t st, logic signed [31:0] elem,
                                      int unsigned idx, logic is_last);
    list_result_t r;
    r.status  = st;
    r.element = elem;
    r.index   = 6'(idx);
    r.count   = 7'(list_len);
    r.last    = is_last;
    awaited_results.push_back(r);
  endfunction

  // Apply one accepted command to the list image and predict its results.
  function automatic void apply_list_cmd(kind_t k, logic [6:0] pos,
                                         logic signed [31:0] val);
    int unsigned p;
    p = pos;
    case (k)
      KIND_INSERT: begin
        // Position is checked before fullness.
        if (p > list_len) begin
          push_result(ST_BADPOS, '0, 0, 1'b1);
        end else if (list_len >= CAPACITY) begin
          push_result(ST_FULL, '0, 0, 1'b1);
        end else begin
          for (int unsigned i = list_len; i > p; i--) list_image[i] = list_image[i - 1];
          list_image[p] = val;
          list_len++;
          push_result(ST_OK, '0, 0, 1'b1);
        end
      end
      KIND_DELETE: begin
        if (p >= list_len) begin
          push_result(ST_BADPOS, '0, 0, 1'b1);
        end else begin
          for (int unsigned i = p; i + 1 < list_len; i++) list_image[i] = list_image[i + 1];
          list_len--;
          push_result(ST_OK, '0, 0, 1'b1);
        end
      end
      KIND_DISPLAY: begin
        if (list_len == 0) begin
          push_result(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < list_len; i++)
            push_result(ST_OK, list_image[i], i, (i + 1 == list_len));
        end
      end
      default: begin
        // Unused kind: nothing changes, one plain acknowledge.
        push_result(ST_OK, '0, 0, 1'b1);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic note_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("MISMATCH %s at result %0d: got %0d, want %0d", what, results_seen, got,
             want);
  endtask

  // Results cannot be held off, so take every strobed result at the edge
  // that ends its cycle.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && strobe) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("unexpected result, status", status, -1);
      end else begin
        want = awaited_results.pop_front();
        if (status !== want.status) note_mismatch("status", status, want.status);
        if (element !== want.element)
          note_mismatch("element", $signed(element), $signed(want.element));
        if (element_index !== want.index)
          note_mismatch("element_index", element_index, want.index);
        if (element_count !== want.count)
          note_mismatch("element_count", element_count, want.count);
        if (last !== want.last) note_mismatch("last", last, want.last);
      end
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Transfer one command. Call at a falling edge; returns at a falling edge
  // with start still high, so the next command can follow without a bubble.
  task automatic send_cmd(kind_t k, logic [6:0] pos, logic signed [31:0] val);
    // Drop start for a random stretch about 18 times in a hundred.
    if (idle_enable && $urandom_range(99) < 18) begin
      start = 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk);
    end
    kind     = k;
    position = pos;
    value    = val;
    start    = 1'b1;
    // Hold the command until an edge sees busy low.
    do @(posedge clk); while (busy);
    apply_list_cmd(k, pos, val);
    @(negedge clk);
  endtask

  // Drop start and wait until every predicted result has arrived.
  task automatic wait_results_drained();
    start = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly random values, with the extremes mixed in.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every command against an empty list.
  task automatic test_empty_list();
    send_cmd(KIND_DISPLAY, 7'd0, 32'sd0);
    send_cmd(KIND_DELETE, 7'd0, 32'sd0);
    send_cmd(KIND_INSERT, 7'd1, 32'sd5);
    send_cmd(KIND_INSERT, 7'd64, -32'sd1);
    send_cmd(KIND_NONE, 7'd127, -32'sd1);
    wait_results_drained();
  endtask

  // Inserts at front, middle and end, deletes at front, middle and end,
  // bad positions, the unused kind and displays in between.
  task automatic test_edit_basics();
    send_cmd(KIND_INSERT, 7'd0, 32'sh7fff_ffff);
    send_cmd(KIND_INSERT, 7'd0, 32'sh8000_0000);
    send_cmd(KIND_INSERT, 7'd2, 32'sd0);
    send_cmd(KIND_INSERT, 7'd1, -32'sd1);
    send_cmd(KIND_INSERT, 7'd5, 32'sd17);
    send_cmd(KIND_INSERT, 7'd127, 32'sd18);
    send_cmd(KIND_DISPLAY, 7'd127, 32'sh5555_aaaa);
    send_cmd(KIND_DELETE, 7'd4, 32'sd0);
    send_cmd(KIND_DELETE, 7'd127, 32'sd0);
    send_cmd(KIND_DELETE, 7'd1, 32'sd0);
    send_cmd(KIND_DELETE, 7'd2, 32'sd0);
    send_cmd(KIND_NONE, 7'd64, 32'sh7fff_ffff);
    send_cmd(KIND_DELETE, 7'd0, 32'sd0);
    send_cmd(KIND_DISPLAY, 7'd0, 32'sd0);
    send_cmd(KIND_DELETE, 7'd0, 32'sd0);
    send_cmd(KIND_DISPLAY, 7'd0, 32'sd0);
    wait_results_drained();
  endtask

  // Fill the store back to back, probe it while full, then empty it.
  task automatic test_full_store();
    // Hold start high throughout the fill: the long stretch with no idling.
    idle_enable = 1'b0;
    while (list_len < CAPACITY)
      send_cmd(KIND_INSERT, 7'($urandom_range(list_len)), pick_value());
    send_cmd(KIND_INSERT, 7'($urandom_range(CAPACITY - 1)), pick_value());
    send_cmd(KIND_INSERT, 7'd64, pick_value());
    send_cmd(KIND_INSERT, 7'd65, pick_value());
    send_cmd(KIND_INSERT, 7'd127, pick_value());
    send_cmd(KIND_DISPLAY, 7'd0, 32'sd0);
    idle_enable = 1'b1;
    send_cmd(KIND_DELETE, 7'd64, 32'sd0);
    send_cmd(KIND_DELETE, 7'd63, 32'sd0);
    send_cmd(KIND_INSERT, 7'd63, pick_value());
    send_cmd(KIND_DISPLAY, 7'd0, 32'sd0);
    while (list_len > 0)
      send_cmd(KIND_DELETE, 7'($urandom_range(list_len - 1)), 32'($urandom()));
    wait_results_drained();
  endtask

  // Random edits that wander between empty and full.
  task automatic test_random_traffic(int n_cmds);
    bit         growing;
    int         r;
    kind_t      k;
    logic [6:0] pos;
    growing = 1'b1;
    for (int n = 0; n < n_cmds; n++) begin
      if (list_len == CAPACITY) growing = 1'b0;
      if (list_len == 0) growing = 1'b1;
      if ($urandom_range(99) < 3) growing = !growing;
      r = $urandom_range(99);
      if (r < 5) k = KIND_NONE;
      else if (r < 15) k = KIND_DISPLAY;
      else if ($urandom_range(99) < (growing ? 70 : 30)) k = KIND_INSERT;
      else k = KIND_DELETE;
      // Mostly legal positions, with edges and out-of-range noise.
      r = $urandom_range(99);
      if (r < 12) begin
        pos = 7'($urandom_range(127));
      end else if (k == KIND_INSERT) begin
        if (r < 25) pos = ($urandom_range(1) != 0) ? 7'(list_len) : 7'd0;
        else pos = 7'($urandom_range(list_len));
      end else begin
        if (list_len == 0) pos = 7'd0;
        else if (r < 25) pos = ($urandom_range(1) != 0) ? 7'(list_len - 1) : 7'd0;
        else pos = 7'($urandom_range(list_len - 1));
      end
      send_cmd(k, pos, pick_value());
    end
    wait_results_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    kind     = KIND_INSERT;
    position = '0;
    value    = '0;
    list_len = 0;
    foreach (list_image[i]) list_image[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_list();
    test_edit_basics();
    test_full_store();
    test_random_traffic(210);

    // Let any stray result show up before the verdict.
    repeat (10) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
